// ===== design/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants for the homography reprojection check.
// ----------------------------------------------------------------------------
package hrc_pkg;

    // Default coordinate width (signed Q.4 pixels)
    localparam int HRC_COORD_WIDTH = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERSPECTIVE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_H22       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON_PX     = 3'd5;

    // Reset values: identity homography, three pixel tolerance
    localparam logic [63:0] RST_COEF_PAIR_0  = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_COEF_PAIR_1  = 64'h0;
    localparam logic [63:0] RST_COEF_PAIR_2  = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_PERSPECTIVE  = 64'h0;
    localparam logic [31:0] RST_COEF_H22     = 32'h0001_0000;
    localparam logic [15:0] RST_EPSILON_PX   = 16'd48;
    localparam logic [31:0] RST_EPSILON_SQ   = 32'd2304;

    // Scale from Q.18 projection numerator to Q.4 result
    localparam int FRAC_SHIFT = 18;
    // |W| at or below this (Q.32) counts as zero
    localparam int W_NEAR_ZERO = 4;

    // Homography coefficients unpacked from the registers
    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h02;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
        logic signed [31:0] h12;
        logic signed [31:0] h20;
        logic signed [31:0] h21;
        logic signed [31:0] h22;
    } hom_coef_t;

    // Status that travels with the quotients
    typedef struct packed {
        logic near_zero;
        logic ovf_x;
        logic ovf_y;
        logic neg_x;
        logic neg_y;
    } div_flags_t;

endpackage

// ===== design/hrc_project.sv =====
// ----------------------------------------------------------------------------
// hrc_project
// Two-stage projection: products of the coefficients with the source point,
// then floored sums into X (Q.18), Y (Q.18) and W (Q.32).
// ----------------------------------------------------------------------------
module hrc_project import hrc_pkg::*; #(
    parameter int CW  = HRC_COORD_WIDTH,
    parameter int SBW = 2 * HRC_COORD_WIDTH + 1,
    parameter int NW  = ((CW + 32) > 50) ? (CW + 32) : 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  hom_coef_t            coef,
    input  logic signed [CW-1:0] src_x,
    input  logic signed [CW-1:0] src_y,
    input  logic [SBW-1:0]       sb_in,
    output logic                 out_valid,
    output logic signed [NW-1:0] num_x,
    output logic signed [NW-1:0] num_y,
    output logic signed [NW-1:0] den,
    output logic [SBW-1:0]       sb_out
);

    localparam int PW = CW + 32;

    logic signed [PW-1:0] p00_next, p01_next, p10_next, p11_next, p20_next, p21_next;
    logic signed [PW-1:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic                 v1_reg, v2_reg;
    logic [SBW-1:0]       sb1_reg, sb2_reg;
    logic signed [NW-1:0] x_next, y_next, w_next;
    logic signed [NW-1:0] x_reg, y_reg, w_reg;

    // Products, exact
    assign p00_next = PW'(coef.h00) * PW'(src_x);
    assign p01_next = PW'(coef.h01) * PW'(src_y);
    assign p10_next = PW'(coef.h10) * PW'(src_x);
    assign p11_next = PW'(coef.h11) * PW'(src_y);
    assign p20_next = PW'(coef.h20) * PW'(src_x);
    assign p21_next = PW'(coef.h21) * PW'(src_y);

    // Floor each product by two bits, add the scaled offset terms
    assign x_next = NW'(p00_reg >>> 2) + NW'(p01_reg >>> 2)
                  + NW'($signed({coef.h02, 2'b00}));
    assign y_next = NW'(p10_reg >>> 2) + NW'(p11_reg >>> 2)
                  + NW'($signed({coef.h12, 2'b00}));
    assign w_next = NW'(p20_reg >>> 2) + NW'(p21_reg >>> 2)
                  + NW'($signed({coef.h22, 16'h0000}));

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            p20_reg <= p20_next;
            p21_reg <= p21_next;
            sb1_reg <= sb_in;
            x_reg   <= x_next;
            y_reg   <= y_next;
            w_reg   <= w_next;
            sb2_reg <= sb1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign num_x     = x_reg;
    assign num_y     = y_reg;
    assign den       = w_reg;
    assign sb_out    = sb2_reg;

endmodule

// ===== design/hrc_divider.sv =====
// ----------------------------------------------------------------------------
// hrc_divider
// Pipelined restoring divider for both coordinates: magnitudes, range check,
// then one quotient bit per stage over CW stages.
// ----------------------------------------------------------------------------
module hrc_divider import hrc_pkg::*; #(
    parameter int CW  = HRC_COORD_WIDTH,
    parameter int SBW = 2 * HRC_COORD_WIDTH + 1,
    parameter int NW  = ((CW + 32) > 50) ? (CW + 32) : 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] num_x,
    input  logic signed [NW-1:0] num_y,
    input  logic signed [NW-1:0] den,
    input  logic [SBW-1:0]       sb_in,
    output logic                 out_valid,
    output div_flags_t           out_flags,
    output logic [CW-1:0]        qx,
    output logic [CW-1:0]        qy,
    output logic [SBW-1:0]       sb_out
);

    localparam int DW = NW + ((CW > FRAC_SHIFT) ? CW : FRAC_SHIFT);

    // Stage A: magnitudes and signs
    logic [NW-1:0]  ux_next, uy_next, ud_next;
    logic [NW-1:0]  ux_reg, uy_reg, uda_reg;
    logic           nx_reg, ny_reg, va_reg;
    logic [SBW-1:0] sba_reg;

    assign ux_next = num_x[NW-1] ? (~num_x + 1'b1) : num_x;
    assign uy_next = num_y[NW-1] ? (~num_y + 1'b1) : num_y;
    assign ud_next = den[NW-1]   ? (~den + 1'b1)   : den;

    // Stage B: near-zero test, range test, scaled dividends
    logic [DW-1:0] nx_sh, ny_sh, dd_sh;
    div_flags_t    flb_next;

    assign nx_sh = DW'(ux_reg) << FRAC_SHIFT;
    assign ny_sh = DW'(uy_reg) << FRAC_SHIFT;
    assign dd_sh = DW'(uda_reg) << CW;

    always_comb begin
        flb_next.near_zero = (uda_reg <= NW'(W_NEAR_ZERO));
        flb_next.ovf_x     = (nx_sh >= dd_sh);
        flb_next.ovf_y     = (ny_sh >= dd_sh);
        flb_next.neg_x     = nx_reg;
        flb_next.neg_y     = ny_reg;
    end

    // Per-stage pipeline: index 0 is the output of stage B
    logic           v_reg  [0:CW];
    div_flags_t     fl_reg [0:CW];
    logic [SBW-1:0] sb_reg [0:CW];
    logic [NW-1:0]  ud_reg [0:CW-1];
    logic [DW-1:0]  rx_reg [0:CW-1];
    logic [DW-1:0]  ry_reg [0:CW-1];
    logic [CW-1:0]  qx_reg [1:CW];
    logic [CW-1:0]  qy_reg [1:CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            va_reg   <= in_valid;
            v_reg[0] <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ux_reg    <= ux_next;
            uy_reg    <= uy_next;
            uda_reg   <= ud_next;
            nx_reg    <= num_x[NW-1] ^ den[NW-1];
            ny_reg    <= num_y[NW-1] ^ den[NW-1];
            sba_reg   <= sb_in;
            fl_reg[0] <= flb_next;
            sb_reg[0] <= sba_reg;
            ud_reg[0] <= uda_reg;
            rx_reg[0] <= nx_sh;
            ry_reg[0] <= ny_sh;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < CW; j++) begin : g_step
        logic [DW-1:0] dsh;
        logic          ge_x, ge_y;
        logic [DW-1:0] rx_next, ry_next;
        logic [CW-1:0] qx_next, qy_next;

        assign dsh     = DW'(ud_reg[j]) << (CW - 1 - j);
        assign ge_x    = (rx_reg[j] >= dsh);
        assign ge_y    = (ry_reg[j] >= dsh);
        assign rx_next = ge_x ? (rx_reg[j] - dsh) : rx_reg[j];
        assign ry_next = ge_y ? (ry_reg[j] - dsh) : ry_reg[j];

        if (j == 0) begin : g_first
            assign qx_next = CW'(ge_x);
            assign qy_next = CW'(ge_y);
        end else begin : g_rest
            assign qx_next = {qx_reg[j][CW-2:0], ge_x};
            assign qy_next = {qy_reg[j][CW-2:0], ge_y};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (adv) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                fl_reg[j+1] <= fl_reg[j];
                sb_reg[j+1] <= sb_reg[j];
                qx_reg[j+1] <= qx_next;
                qy_reg[j+1] <= qy_next;
            end
        end

        if (j < CW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    ud_reg[j+1] <= ud_reg[j];
                    rx_reg[j+1] <= rx_next;
                    ry_reg[j+1] <= ry_next;
                end
            end
        end
    end

    assign out_valid = v_reg[CW];
    assign out_flags = fl_reg[CW];
    assign qx        = qx_reg[CW];
    assign qy        = qy_reg[CW];
    assign sb_out    = sb_reg[CW];

endmodule

// ===== design/hrc_check.sv =====
// ----------------------------------------------------------------------------
// hrc_check
// Signs the quotients, tests the coordinate range, and compares the squared
// reprojection error with the squared tolerance.
// ----------------------------------------------------------------------------
module hrc_check import hrc_pkg::*; #(
    parameter int CW  = HRC_COORD_WIDTH,
    parameter int SBW = 2 * HRC_COORD_WIDTH + 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  div_flags_t     flags,
    input  logic [CW-1:0]  qx,
    input  logic [CW-1:0]  qy,
    input  logic [SBW-1:0] sb_in,
    input  logic [15:0]    eps,
    input  logic [31:0]    eps_sq,
    output logic           tail_valid,
    output logic           tail_correct,
    output logic           tail_degenerate
);

    localparam int EW = CW + 2;
    localparam int MW = (EW > 16) ? EW : 16;

    // Stage 1: sign and range
    logic                 negx, negy;
    logic [CW-1:0]        limx, limy;
    logic                 deg_next;
    logic signed [CW:0]   px_next, py_next;
    logic signed [CW:0]   px_reg, py_reg;
    logic                 v1_reg, deg1_reg, pv1_reg;
    logic signed [CW-1:0] bx1_reg, by1_reg;

    assign negx    = flags.neg_x && (qx != '0);
    assign negy    = flags.neg_y && (qy != '0);
    assign limx    = {1'b0, {(CW-1){1'b1}}} + CW'(negx);
    assign limy    = {1'b0, {(CW-1){1'b1}}} + CW'(negy);
    assign deg_next = flags.near_zero || flags.ovf_x || flags.ovf_y
                    || (qx > limx) || (qy > limy);
    assign px_next = negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign py_next = negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    // Stage 2: error magnitudes
    logic signed [EW-1:0] dx, dy;
    logic [EW-1:0]        ex_next, ey_next;
    logic [EW-1:0]        ex_reg, ey_reg;
    logic                 v2_reg, deg2_reg, pv2_reg;

    assign dx      = EW'(px_reg) - EW'(bx1_reg);
    assign dy      = EW'(py_reg) - EW'(by1_reg);
    assign ex_next = dx[EW-1] ? (~dx + 1'b1) : dx;
    assign ey_next = dy[EW-1] ? (~dy + 1'b1) : dy;

    // Stage 3: per-axis bound and squares
    logic [MW-1:0] exm, eym;
    logic          small_next;
    logic [31:0]   sqx_next, sqy_next;
    logic [31:0]   sqx_reg, sqy_reg;
    logic          v3_reg, deg3_reg, pv3_reg, small_reg;

    assign exm        = MW'(ex_reg);
    assign eym        = MW'(ey_reg);
    assign small_next = (exm <= MW'(eps)) && (eym <= MW'(eps));
    assign sqx_next   = 32'(exm[15:0]) * 32'(exm[15:0]);
    assign sqy_next   = 32'(eym[15:0]) * 32'(eym[15:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            deg1_reg  <= deg_next;
            pv1_reg   <= sb_in[2*CW];
            bx1_reg   <= $signed(sb_in[2*CW-1:CW]);
            by1_reg   <= $signed(sb_in[CW-1:0]);
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            deg2_reg  <= deg1_reg;
            pv2_reg   <= pv1_reg;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            small_reg <= small_next;
            deg3_reg  <= deg2_reg;
            pv3_reg   <= pv2_reg;
        end
    end

    // Final sum and compare feed the output register
    logic ok;
    assign ok = small_reg && (({1'b0, sqx_reg} + {1'b0, sqy_reg}) <= {1'b0, eps_sq});

    assign tail_valid      = v3_reg;
    assign tail_correct    = pv3_reg && !deg3_reg && ok;
    assign tail_degenerate = pv3_reg && deg3_reg;

endmodule

// ===== design/homography_reprojection_check.sv =====
// ----------------------------------------------------------------------------
// homography_reprojection_check
// Projects each source keypoint through a 3x3 homography and tests the
// matched destination point against a pixel tolerance.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the skid slot is free and returns one result
// per request, in order. A request passes through the projection, the magnitude
// and range checks, the restoring divider (one quotient bit per stage, X and Y
// side by side), the error test, and the output register. A two-entry output
// (output register plus skid slot) lets the pipeline keep taking requests
// while one result waits. The user must write configuration only while idle;
// the block itself does not enforce it. The epsilon_px value is stored in
// epsilon_reg and its square is then registered in eps_sq_reg.
module homography_reprojection_check import hrc_pkg::*; #(
    parameter int COORD_WIDTH = HRC_COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pair_valid,
    input  logic signed [COORD_WIDTH-1:0] s_src_x,
    input  logic signed [COORD_WIDTH-1:0] s_src_y,
    input  logic signed [COORD_WIDTH-1:0] s_dst_x,
    input  logic signed [COORD_WIDTH-1:0] s_dst_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_correct,
    output logic                          m_degenerate,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wr_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int SBW = 2 * CW + 1;
    localparam int NW  = ((CW + 32) > 50) ? (CW + 32) : 50;

    // Configuration registers
    logic [63:0] coef_pair_0_reg, coef_pair_1_reg, coef_pair_2_reg, perspective_reg;
    logic [31:0] coef_h22_reg;
    logic [15:0] epsilon_reg;
    logic [31:0] eps_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_pair_0_reg <= RST_COEF_PAIR_0;
            coef_pair_1_reg <= RST_COEF_PAIR_1;
            coef_pair_2_reg <= RST_COEF_PAIR_2;
            perspective_reg <= RST_PERSPECTIVE;
            coef_h22_reg    <= RST_COEF_H22;
            epsilon_reg     <= RST_EPSILON_PX;
            eps_sq_reg      <= RST_EPSILON_SQ;
        end else begin
            eps_sq_reg <= 32'(epsilon_reg) * 32'(epsilon_reg);
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_COEF_PAIR_0: coef_pair_0_reg <= cfg_wr_data;
                    REG_COEF_PAIR_1: coef_pair_1_reg <= cfg_wr_data;
                    REG_COEF_PAIR_2: coef_pair_2_reg <= cfg_wr_data;
                    REG_PERSPECTIVE: perspective_reg <= cfg_wr_data;
                    REG_COEF_H22:    coef_h22_reg    <= cfg_wr_data[31:0];
                    REG_EPSILON_PX:  epsilon_reg     <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Unpack coefficients
    hom_coef_t coef;
    always_comb begin
        coef.h00 = coef_pair_0_reg[63:32];
        coef.h01 = coef_pair_0_reg[31:0];
        coef.h02 = coef_pair_1_reg[63:32];
        coef.h10 = coef_pair_1_reg[31:0];
        coef.h11 = coef_pair_2_reg[63:32];
        coef.h12 = coef_pair_2_reg[31:0];
        coef.h20 = perspective_reg[63:32];
        coef.h21 = perspective_reg[31:0];
        coef.h22 = coef_h22_reg;
    end

    // Pipeline advances whenever the skid slot is free
    logic skid_v_reg;
    logic adv;
    assign adv     = !skid_v_reg;
    assign s_ready = adv;

    logic [SBW-1:0] sb_in;
    assign sb_in = {s_pair_valid, s_dst_x, s_dst_y};

    logic                 pv;
    logic signed [NW-1:0] num_x, num_y, den;
    logic [SBW-1:0]       sb_p;

    hrc_project #(.CW(CW), .SBW(SBW), .NW(NW)) u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .coef      (coef),
        .src_x     (s_src_x),
        .src_y     (s_src_y),
        .sb_in     (sb_in),
        .out_valid (pv),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .sb_out    (sb_p)
    );

    logic           dv;
    div_flags_t     dflags;
    logic [CW-1:0]  qx, qy;
    logic [SBW-1:0] sb_d;

    hrc_divider #(.CW(CW), .SBW(SBW), .NW(NW)) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pv),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .sb_in     (sb_p),
        .out_valid (dv),
        .out_flags (dflags),
        .qx        (qx),
        .qy        (qy),
        .sb_out    (sb_d)
    );

    logic tail_v, tail_ok, tail_deg;

    hrc_check #(.CW(CW), .SBW(SBW)) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (dv),
        .flags           (dflags),
        .qx              (qx),
        .qy              (qy),
        .sb_in           (sb_d),
        .eps             (epsilon_reg),
        .eps_sq          (eps_sq_reg),
        .tail_valid      (tail_v),
        .tail_correct    (tail_ok),
        .tail_degenerate (tail_deg)
    );

    // Output register and skid slot
    logic m_valid_reg, m_ok_reg, m_deg_reg;
    logic skid_ok_reg, skid_deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= skid_v_reg || tail_v;
            skid_v_reg  <= 1'b0;
        end else if (tail_v && adv) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_ok_reg  <= skid_v_reg ? skid_ok_reg  : tail_ok;
            m_deg_reg <= skid_v_reg ? skid_deg_reg : tail_deg;
        end else if (tail_v && adv) begin
            skid_ok_reg  <= tail_ok;
            skid_deg_reg <= tail_deg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_correct = m_ok_reg;
    assign m_degenerate = m_deg_reg;

    // The skid slot only fills behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> m_valid_reg)
        else $error("skid slot full with no result held");

    // A full skid slot stops new requests
    a_skid_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> !s_ready)
        else $error("request taken while skid slot full");

    // A degenerate pair is never marked correct
    a_deg_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_ok_reg && m_deg_reg))
        else $error("result both correct and degenerate");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !skid_v_reg)
        else $error("output not empty after reset");

endmodule

// ===== test/tb_homography_reprojection_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for homography_reprojection_check
// Drives keypoint pairs through several homography and tolerance settings,
// predicts each inlier/degenerate verdict in fixed point and checks results
// in order under random idling and a long output stall.
// ----------------------------------------------------------------------------

// In-order store of predicted verdicts and the mismatch count
class verdict_board;
    bit exp_correct[$];
    bit exp_degen[$];
    int errors;
    int mismatches;
    int checked;

    function void note_request(bit correct, bit degen);
        exp_correct = {exp_correct, correct};
        exp_degen   = {exp_degen, degen};
    endfunction

    function void check_result(bit correct, bit degen);
        bit ec;
        bit ed;
        if (exp_correct.size() == 0) begin
            errors++;
            $display("ERROR: result with nothing expected");
            return;
        end
        ec = exp_correct.pop_front();
        ed = exp_degen.pop_front();
        checked++;
        if (ec !== correct || ed !== degen) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH #%0d: is_correct exp %0b got %0b, degenerate exp %0b got %0b",
                         checked, ec, correct, ed, degen);
        end
    endfunction

    function int pending();
        return exp_correct.size();
    endfunction
endclass

module tb_homography_reprojection_check;
    import hrc_pkg::*;

    localparam int CW        = HRC_COORD_WIDTH;
    localparam int LATENCY   = CW + 8;
    localparam int MAX_CYCLE = 400000;
    // Index past the register list
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_pair_valid = 1'b0;
    logic signed [CW-1:0] s_src_x = '0;
    logic signed [CW-1:0] s_src_y = '0;
    logic signed [CW-1:0] s_dst_x = '0;
    logic signed [CW-1:0] s_dst_y = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_is_correct;
    logic                 m_degenerate;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Predictor copy of the registers
    logic [63:0] m_cp0, m_cp1, m_cp2, m_persp;
    logic [31:0] m_h22;
    logic [15:0] m_eps;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int cycle_cnt = 0;
    int requests;
    int inliers;
    int degens;
    verdict_board board;

    homography_reprojection_check #(.COORD_WIDTH(CW)) dut (.*);

    always #10 aclk = ~aclk;

    // Global timeout
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("timeout, %0d results outstanding", board.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random idling or held off, check each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_is_correct, m_degenerate);
            if (m_is_correct) inliers++;
            if (m_degenerate) degens++;
        end
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // floor(v / 4)
    function automatic longint floor4(longint v);
        return v >>> 2;
    endfunction

    // Project num/den to Q.4 with magnitude truncated; returns 0 if out of range
    function automatic bit project_q4(longint num, longint den, output longint res);
        logic [127:0] un;
        logic [127:0] q;
        logic [63:0]  ud;
        longint lim;
        bit neg;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        un = un << 18;
        q = un / ud;
        neg = ((num < 0) != (den < 0)) && (q != 0);
        lim = neg ? (64'sd1 <<< (CW - 1)) : ((64'sd1 <<< (CW - 1)) - 1);
        if (q > lim) return 1'b0;
        res = neg ? -longint'(q) : longint'(q);
        return 1'b1;
    endfunction

    // Predict the verdict for one keypoint pair
    task automatic predict_verdict(input bit pv, input logic signed [CW-1:0] sx, sy, dx, dy,
                                   output bit correct, output bit degen);
        longint x, y, bx, by, bigx, bigy, bigw, px, py, ex, ey, eps;
        bit okx, oky;
        x = sx; y = sy; bx = dx; by = dy;
        correct = 1'b0;
        degen = 1'b0;
        px = 0; py = 0;
        if (!pv) return;
        bigx = floor4(longint'($signed(m_cp0[63:32])) * x)
             + floor4(longint'($signed(m_cp0[31:0])) * y)
             + longint'($signed(m_cp1[63:32])) * 4;
        bigy = floor4(longint'($signed(m_cp1[31:0])) * x)
             + floor4(longint'($signed(m_cp2[63:32])) * y)
             + longint'($signed(m_cp2[31:0])) * 4;
        bigw = floor4(longint'($signed(m_persp[63:32])) * x)
             + floor4(longint'($signed(m_persp[31:0])) * y)
             + longint'($signed(m_h22)) * 65536;
        if (bigw <= W_NEAR_ZERO && bigw >= -W_NEAR_ZERO) begin
            degen = 1'b1;
            return;
        end
        okx = project_q4(bigx, bigw, px);
        oky = project_q4(bigy, bigw, py);
        if (!okx || !oky) begin
            degen = 1'b1;
            return;
        end
        ex = px - bx; if (ex < 0) ex = -ex;
        ey = py - by; if (ey < 0) ey = -ey;
        eps = m_eps;
        correct = (ex <= eps) && (ey <= eps) && (ex * ex + ey * ey <= eps * eps);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_COEF_PAIR_0: m_cp0 = val;
            REG_COEF_PAIR_1: m_cp1 = val;
            REG_COEF_PAIR_2: m_cp2 = val;
            REG_PERSPECTIVE: m_persp = val;
            REG_COEF_H22:    m_h22 = val[31:0];
            REG_EPSILON_PX:  m_eps = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_homography(input logic [63:0] p0, p1, p2, pp, input logic [31:0] h22,
                                   input logic [15:0] eps);
        write_reg(REG_COEF_PAIR_0, p0);
        write_reg(REG_COEF_PAIR_1, p1);
        write_reg(REG_COEF_PAIR_2, p2);
        write_reg(REG_PERSPECTIVE, pp);
        write_reg(REG_COEF_H22, {32'h0, h22});
        write_reg(REG_EPSILON_PX, {48'h0, eps});
        // stray index must be ignored
        write_reg(REG_UNMAPPED, 64'hDEAD_BEEF_DEAD_BEEF);
        repeat (2) @(posedge aclk);
    endtask

    // Offer one request, hold it until accepted
    task automatic send_pair(input bit pv, input logic signed [CW-1:0] sx, sy, dx, dy);
        bit c, d;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pair_valid <= pv;
        s_src_x <= sx; s_src_y <= sy; s_dst_x <= dx; s_dst_y <= dy;
        predict_verdict(pv, sx, sy, dx, dy, c, d);
        do @(posedge aclk); while (!s_ready);
        board.note_request(c, d);
        requests++;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(8000)) - 4000);
            2: return ($urandom_range(1)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(400)) - 200);
        endcase
    endfunction

    // Random pair, mostly a destination near the source point so inliers occur
    task automatic send_random();
        logic signed [CW-1:0] sx, sy, dx, dy;
        bit c, d;
        bit pv;
        longint px, py;
        pv = ($urandom_range(9) != 0);
        sx = rand_coord();
        sy = rand_coord();
        dx = rand_coord();
        dy = rand_coord();
        if ($urandom_range(3) != 0) begin
            // aim at the source point with a small offset
            predict_verdict(1'b1, sx, sy, sx, sy, c, d);
            px = sx + ($signed($urandom_range(2 * m_eps + 20)) - m_eps - 10);
            py = sy + ($signed($urandom_range(2 * m_eps + 20)) - m_eps - 10);
            dx = CW'(px);
            dy = CW'(py);
        end
        send_pair(pv, sx, sy, dx, dy);
    endtask

    // Drop the request, wait for all results, then let the pipeline drain
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    initial begin
        board = new();
        requests = 0;
        inliers = 0;
        degens = 0;
        hold_off = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 86;
        m_cp0 = RST_COEF_PAIR_0; m_cp1 = RST_COEF_PAIR_1; m_cp2 = RST_COEF_PAIR_2;
        m_persp = RST_PERSPECTIVE; m_h22 = RST_COEF_H22; m_eps = RST_EPSILON_PX;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset identity, extremes, invalid pair, tolerance edge
        send_pair(1'b1, CW'(0), CW'(0), CW'(0), CW'(0));
        send_pair(1'b0, CW'(0), CW'(0), CW'(0), CW'(0));
        send_pair(1'b1, CMAX, CMIN, CMAX, CMIN);
        send_pair(1'b1, CMIN, CMAX, CMIN, CMAX);
        send_pair(1'b1, CW'(100), CW'(100), CW'(148), CW'(100));
        send_pair(1'b1, CW'(100), CW'(100), CW'(149), CW'(100));
        send_pair(1'b1, CW'(100), CW'(100), CW'(134), CW'(134));
        send_pair(1'b1, CW'(-1), CW'(-1), {CW{1'b1}}, CW'(0));
        send_pair(1'b0, CMAX, CMAX, CMIN, CMIN);
        drain();

        // Zero W everywhere: every valid pair is degenerate
        load_homography(RST_COEF_PAIR_0, 64'h0, RST_COEF_PAIR_2, 64'h0, 32'h0, 16'hFFFF);
        send_pair(1'b1, CW'(5), CW'(5), CW'(5), CW'(5));
        send_pair(1'b0, CW'(5), CW'(5), CW'(5), CW'(5));
        drain();
        // Scale by 2 with a shift: big coordinates overflow, zero tolerance
        load_homography(64'h0002_0000_0000_0000, 64'h0010_0000_0000_0000,
                        64'h0002_0000_FFF0_0000, 64'h0, 32'h0001_0000, 16'h0);
        send_pair(1'b1, CMAX, CW'(0), CW'(0), CW'(0));
        send_pair(1'b1, CW'(16), CW'(16), CW'(32 + 16 * 16 * 16 * 16),
                  CW'(32 - 16 * 16 * 16 * 16));
        send_pair(1'b1, CW'(0), CMIN, CW'(0), CW'(0));
        drain();
        // Extreme coefficients, perspective terms, negative h22
        load_homography(64'h8000_0000_7FFF_FFFF, 64'hFFFF_FFFF_8000_0000,
                        64'h7FFF_FFFF_0000_0001, 64'h7FFF_FFFF_8000_0000,
                        32'h8000_0000, 16'h8000);
        send_pair(1'b1, CW'(1), CW'(1), CW'(0), CW'(0));
        send_pair(1'b1, CMIN, CMAX, CW'(0), CW'(0));
        send_pair(1'b1, CW'(0), CW'(0), CMIN, CMIN);
        drain();

        // Random phases over several settings and idling profiles
        for (int ph = 0; ph < 7; ph++) begin
            logic [63:0] pp;
            case (ph)
                0: load_homography(RST_COEF_PAIR_0, 64'h0, RST_COEF_PAIR_2, 64'h0,
                                   RST_COEF_H22, RST_EPSILON_PX);
                1: begin
                    send_idle_pct = 86; recv_idle_pct = 19;
                    // mild rotation-like matrix, small perspective
                    pp = {32'($signed($urandom_range(2000)) - 1000),
                          32'($signed($urandom_range(2000)) - 1000)};
                    load_homography(64'h0000_F000_0000_2000, {32'h0003_0000, 32'hFFFF_E000},
                                    {32'h0000_F000, 32'hFFFE_0000}, pp, 32'h0001_0000,
                                    16'd80);
                end
                2: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    load_homography({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom},
                                    $urandom, 16'($urandom));
                end
                3: load_homography(64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000_0000_0000,
                                   64'h0, 32'h0002_0000, 16'd4000);
                4: load_homography(64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000_0000_0000,
                                   64'h0, 32'h0001_0000, 16'hFFFF);
                5: begin
                    send_idle_pct = 19; recv_idle_pct = 86;
                    load_homography(64'h0000_8000_0000_0000, 64'h0000_4000_0000_0000,
                                    64'h0000_8000_0000_0000, 64'h0, 32'h0000_0001, 16'd8);
                end
                default: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    load_homography(RST_COEF_PAIR_0, 64'h0, RST_COEF_PAIR_2, 64'h0,
                                    RST_COEF_H22, RST_EPSILON_PX);
                end
            endcase
            if (ph == 6) begin
                // hold off the receiver long enough for the block to back up
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    repeat (100) send_random();
                join
            end else begin
                repeat (100) send_random();
            end
            drain();
        end

        $display("Sent %0d pairs over directed and seven random settings.", requests);
        $display("Saw %0d inliers and %0d degenerate projections.", inliers, degens);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors, %0d mismatches", board.errors, board.mismatches);
            $display("FAIL");
        end
        $finish;
    end
endmodule
